### sv/c40idw_pkg.sv
// c40idw_pkg: shared types, constants and the digit-to-ASCII map for the C40 id-word decoder.
// No dependencies; compile first.
`timescale 1ns / 1ps

package c40idw_pkg;

    typedef logic [6:0]  t_char;
    typedef logic [5:0]  t_digit;
    typedef logic [15:0] t_half_word;

    // three characters of one halfword and whether all three digits are legal
    typedef struct packed {
        t_char c0;
        t_char c1;
        t_char c2;
        logic  ok;
    } t_half;

    // reciprocal constants: floor(x/1600) and floor(x/40) for any 16-bit x
    localparam int unsigned   RECIP_1600_SHIFT = 32;
    localparam logic [21:0]   RECIP_1600       = 22'd2684355;
    localparam int unsigned   RECIP_40_SHIFT   = 22;
    localparam logic [16:0]   RECIP_40         = 17'd104858;

    localparam t_digit DIGIT_NUM_FIRST   = 6'd4;
    localparam t_digit DIGIT_NUM_LAST    = 6'd13;
    localparam t_digit DIGIT_ALPHA_FIRST = 6'd14;
    localparam t_digit DIGIT_ALPHA_LAST  = 6'd39;
    localparam t_char  ASCII_ZERO        = 7'h30;
    localparam t_char  ASCII_UPPER_A     = 7'h41;
    localparam t_char  ASCII_NONE        = 7'h00;

    localparam logic [2:0] CHARS_PER_HALF = 3'd3;
    localparam logic [2:0] CHARS_PER_WORD = 3'd6;

    function automatic t_char digit_to_ascii(input t_digit d);
        t_char c;
        case (d) inside
            [DIGIT_NUM_FIRST:DIGIT_NUM_LAST]: begin
                c = ASCII_ZERO + {1'b0, d} - {1'b0, DIGIT_NUM_FIRST};
            end
            [DIGIT_ALPHA_FIRST:DIGIT_ALPHA_LAST]: begin
                c = ASCII_UPPER_A + {1'b0, d} - {1'b0, DIGIT_ALPHA_FIRST};
            end
            default: begin
                c = ASCII_NONE;
            end
        endcase
        return c;
    endfunction

endpackage

### sv/c40idw_if.sv
// c40idw_in_if / c40idw_out_if: valid/ready channels of the C40 id-word decoder.
// No dependencies beyond the language.
`timescale 1ns / 1ps

interface c40idw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] id_word;
    logic        list_start;

    modport source (output valid, output id_word, output list_start, input ready);
    modport sink   (input valid, input id_word, input list_start, output ready);
endinterface

interface c40idw_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_a;
    logic [6:0] char_b;
    logic [6:0] char_c;
    logic [6:0] char_d;
    logic [6:0] char_e;
    logic [6:0] char_f;
    logic [2:0] chars_emitted;
    logic       list_ended;
    logic       decode_failed;
    logic [5:0] total_chars;

    modport source (
        output valid, output char_a, output char_b, output char_c, output char_d,
        output char_e, output char_f, output chars_emitted, output list_ended,
        output decode_failed, output total_chars, input ready
    );
    modport sink (
        input valid, input char_a, input char_b, input char_c, input char_d,
        input char_e, input char_f, input chars_emitted, input list_ended,
        input decode_failed, input total_chars, output ready
    );
endinterface

### sv/c40_id_word_decoder_unit.sv
// c40_id_word_decoder_unit: C40 identifier-word decoder, top level.
// Depends on c40idw_pkg, c40idw_if and c40idw_half_split.
//
//   port    | dir | beat contents
//   --------+-----+----------------------------------------------------------
//   i_in    | in  | id_word[31:0], list_start
//   o_out   | out | char_a..char_f, chars_emitted, list_ended, decode_failed,
//           |     | total_chars
//
// One beat per cycle while o_out is ready; path: input register, then result register.
// Count, end and failure flags update in the decode cycle, so each word sees the
// state left by the one before it.
// A held result register stalls the input register, which then deasserts ready.
// Synchronous active-low reset clears valids and list state.
`timescale 1ns / 1ps

module c40_id_word_decoder_unit #(
    parameter int unsigned MAX_CHARS = 36
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    c40idw_in_if.sink          i_in,
    c40idw_out_if.source       o_out
);
    import c40idw_pkg::*;

    typedef struct packed {
        t_char      char_a;
        t_char      char_b;
        t_char      char_c;
        t_char      char_d;
        t_char      char_e;
        t_char      char_f;
        logic [2:0] emitted;
        logic       ended;
        logic       failed;
        logic [5:0] total;
    } t_result;

    logic        r_s1_valid;
    logic [31:0] r_s1_word;
    logic        r_s1_start;
    logic        r_o_valid;
    t_result     r_res;
    t_result     n_res;
    logic [5:0]  r_total;
    logic        r_ended;
    logic        r_failed;

    logic        adv;
    logic [5:0]  eff_total;
    logic        eff_ended;
    logic        eff_failed;
    logic [2:0]  need;
    logic [6:0]  sum;
    logic        fits;
    logic        hi_nz;
    logic        ok;
    t_half       lo_half;
    t_half       hi_half;

    assign adv        = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || adv;

    c40idw_half_split u_lo (.i_half(r_s1_word[15:0]),  .o_half(lo_half));
    c40idw_half_split u_hi (.i_half(r_s1_word[31:16]), .o_half(hi_half));

    always_comb begin
        eff_total  = r_s1_start ? 6'd0 : r_total;
        eff_ended  = r_s1_start ? 1'b0 : r_ended;
        eff_failed = r_s1_start ? 1'b0 : r_failed;
        hi_nz      = r_s1_word[31:16] != '0;
        need       = hi_nz ? CHARS_PER_WORD : CHARS_PER_HALF;
        sum        = {1'b0, eff_total} + {4'd0, need};
        fits       = sum <= 7'(MAX_CHARS);
        ok         = fits && lo_half.ok && (!hi_nz || hi_half.ok);

        n_res         = '0;
        n_res.ended   = eff_ended;
        n_res.failed  = eff_failed;
        n_res.total   = eff_total;
        if (!eff_ended && !eff_failed) begin
            if (r_s1_word == '0) begin
                n_res.ended = 1'b1;
            end else if (ok) begin
                n_res.char_a  = lo_half.c0;
                n_res.char_b  = lo_half.c1;
                n_res.char_c  = lo_half.c2;
                n_res.char_d  = hi_nz ? hi_half.c0 : ASCII_NONE;
                n_res.char_e  = hi_nz ? hi_half.c1 : ASCII_NONE;
                n_res.char_f  = hi_nz ? hi_half.c2 : ASCII_NONE;
                n_res.emitted = need;
                n_res.total   = sum[5:0];
            end else begin
                n_res.failed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_total    <= '0;
            r_ended    <= 1'b0;
            r_failed   <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
                r_total   <= n_res.total;
                r_ended   <= n_res.ended;
                r_failed  <= n_res.failed;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_word  <= i_in.id_word;
            r_s1_start <= i_in.list_start;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.char_a        = r_res.char_a;
    assign o_out.char_b        = r_res.char_b;
    assign o_out.char_c        = r_res.char_c;
    assign o_out.char_d        = r_res.char_d;
    assign o_out.char_e        = r_res.char_e;
    assign o_out.char_f        = r_res.char_f;
    assign o_out.chars_emitted = r_res.emitted;
    assign o_out.list_ended    = r_res.ended;
    assign o_out.decode_failed = r_res.failed;
    assign o_out.total_chars   = r_res.total;

    a_total_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= 6'(MAX_CHARS))
        else $error("character count beyond limit");

    a_blank_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_res.emitted == 3'd0) |->
        (r_res.char_a == ASCII_NONE && r_res.char_b == ASCII_NONE
         && r_res.char_c == ASCII_NONE && r_res.char_d == ASCII_NONE
         && r_res.char_e == ASCII_NONE && r_res.char_f == ASCII_NONE))
        else $error("characters present with zero count");

    a_emit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_res.emitted != 3'd0) |-> (!r_res.failed && !r_res.ended))
        else $error("characters emitted in ended or failed list");

    a_closed_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_s1_start && (r_ended || r_failed)) |=>
        (r_res.emitted == 3'd0 && $stable(r_total)))
        else $error("closed list changed");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> (r_s1_valid && $stable(r_s1_word)))
        else $error("input register lost a beat");

endmodule

### sv/c40idw_half_split.sv
// c40idw_half_split: splits one halfword into three base-40 digits and maps them to ASCII.
// Depends on c40idw_pkg. Purely combinational.
`timescale 1ns / 1ps

module c40idw_half_split (
    input  c40idw_pkg::t_half_word i_half,
    output c40idw_pkg::t_half      o_half
);
    import c40idw_pkg::*;

    logic [15:0] x;
    logic [37:0] p_hi;
    logic [32:0] p_mid;
    t_digit      d1;
    logic [10:0] q;
    logic [10:0] d2_w;
    logic [15:0] d3_w;
    t_digit      d2;
    t_digit      d3;

    assign x     = i_half - 16'd1;
    assign p_hi  = {22'd0, x} * {16'd0, RECIP_1600};
    assign p_mid = {17'd0, x} * {16'd0, RECIP_40};
    assign d1    = p_hi[RECIP_1600_SHIFT +: 6];
    assign q     = p_mid[RECIP_40_SHIFT +: 11];
    assign d2_w  = q - ({5'd0, d1} * 11'd40);
    assign d3_w  = x - ({5'd0, q} * 16'd40);
    assign d2    = d2_w[5:0];
    assign d3    = d3_w[5:0];

    always_comb begin
        o_half.c0 = digit_to_ascii(d1);
        o_half.c1 = digit_to_ascii(d2);
        o_half.c2 = digit_to_ascii(d3);
        o_half.ok = (i_half != '0) && (o_half.c0 != ASCII_NONE)
                    && (o_half.c1 != ASCII_NONE) && (o_half.c2 != ASCII_NONE);
    end

endmodule

### sim/tb_c40_id_word_decoder_unit.sv
// tb_c40_id_word_decoder_unit: self-checking testbench for the C40 id-word decoder.
// Depends on c40idw_pkg, c40idw_if and the c40_id_word_decoder_unit RTL.
// An in-bench decoder predicts every result beat; a monitor checks each one against it.
`timescale 1ns / 1ps

module tb_c40_id_word_decoder_unit;
    import c40idw_pkg::*;

    localparam int unsigned LIST_CHAR_LIMIT = 36;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;

    typedef enum logic [0:0] {RX_FREE, RX_PATTERN} t_rx_mode;

    typedef struct packed {
        t_char      char_a;
        t_char      char_b;
        t_char      char_c;
        t_char      char_d;
        t_char      char_e;
        t_char      char_f;
        logic [2:0] chars_emitted;
        logic       list_ended;
        logic       decode_failed;
        logic [5:0] total_chars;
    } t_c40_beat;

    logic clk;
    logic rst_n;

    c40idw_in_if  in_ch ();
    c40idw_out_if out_ch ();

    c40_id_word_decoder_unit #(
        .MAX_CHARS(LIST_CHAR_LIMIT)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // decoder state mirrored by the predictor
    int unsigned list_total;
    logic        list_done;
    logic        list_bad;
    int unsigned handled_words;

    t_c40_beat   expected_beats[$];
    int unsigned mismatch_count;

    // sender / receiver pacing
    logic        tx_bursty;
    int unsigned burst_left;
    t_rx_mode    rx_mode = RX_FREE;
    logic [15:0] rx_mask = 16'hFFFF;
    int unsigned hold_req = 0;
    int unsigned hold_len = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_half_word pack_half(input int unsigned d1, input int unsigned d2,
                                             input int unsigned d3);
        return t_half_word'(d1 * 1600 + d2 * 40 + d3 + 1);
    endfunction

    function automatic t_half_word random_valid_half();
        return pack_half($urandom_range(4, 39), $urandom_range(4, 39), $urandom_range(4, 39));
    endfunction

    function automatic t_char c40_char(input int unsigned d);
        if (d >= DIGIT_NUM_FIRST && d <= DIGIT_NUM_LAST)
            return ASCII_ZERO + t_char'(d - DIGIT_NUM_FIRST);
        if (d >= DIGIT_ALPHA_FIRST && d <= DIGIT_ALPHA_LAST)
            return ASCII_UPPER_A + t_char'(d - DIGIT_ALPHA_FIRST);
        return ASCII_NONE;
    endfunction

    function automatic logic split_half(input t_half_word h, output t_char [2:0] c);
        int unsigned digit [3];
        int unsigned rest;
        c = '0;
        if (h == '0)
            return 1'b0;
        rest     = int'(h) - 1;
        digit[0] = rest / 1600;
        rest     = rest % 1600;
        digit[1] = rest / 40;
        digit[2] = rest % 40;
        for (int k = 0; k < 3; k++) begin
            c[k] = c40_char(digit[k]);
            if (c[k] == ASCII_NONE)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_word(input logic [31:0] w, input logic s);
        t_c40_beat   b;
        t_char [2:0] lo_c;
        t_char [2:0] hi_c;
        logic        lo_ok;
        logic        hi_ok;
        int unsigned need;
        b    = '0;
        lo_c = '0;
        hi_c = '0;
        if (s) begin
            list_total = 0;
            list_done  = 1'b0;
            list_bad   = 1'b0;
        end
        if (!list_done && !list_bad) begin
            handled_words++;
            if (w == '0) begin
                list_done = 1'b1;
            end else begin
                need  = (w[31:16] != '0) ? 6 : 3;
                lo_ok = split_half(w[15:0], lo_c);
                hi_ok = 1'b1;
                if (w[31:16] != '0)
                    hi_ok = split_half(w[31:16], hi_c);
                if (list_total + need <= LIST_CHAR_LIMIT && lo_ok && hi_ok) begin
                    b.char_a        = lo_c[0];
                    b.char_b        = lo_c[1];
                    b.char_c        = lo_c[2];
                    b.char_d        = hi_c[0];
                    b.char_e        = hi_c[1];
                    b.char_f        = hi_c[2];
                    b.chars_emitted = 3'(need);
                    list_total      = list_total + need;
                end else begin
                    list_bad = 1'b1;
                end
            end
        end
        b.list_ended    = list_done;
        b.decode_failed = list_bad;
        b.total_chars   = 6'(list_total);
        expected_beats.insert(expected_beats.size(), b);
    endtask

    task automatic send_word(input logic [31:0] w, input logic s);
        int unsigned gap;
        if (tx_bursty && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid      <= 1'b1;
        in_ch.id_word    <= w;
        in_ch.list_start <= s;
        do @(posedge clk); while (!in_ch.ready);
        predict_word(w, s);
        if (burst_left != 0)
            burst_left--;
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_beats.size() != 0);
    endtask

    // well-formed list with random content, now and then one corrupted word
    task automatic send_random_list();
        int unsigned n;
        int unsigned bad_at;
        t_half_word  lo;
        t_half_word  hi;
        n      = $urandom_range(1, 9);
        bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < n; i++) begin
            lo = random_valid_half();
            hi = ($urandom_range(0, 3) == 0) ? '0 : random_valid_half();
            if (i == bad_at) begin
                case ($urandom_range(0, 2))
                    0: lo = t_half_word'($urandom());
                    1: hi = t_half_word'($urandom());
                    default: lo = '0;
                endcase
            end
            send_word({hi, lo}, i == 0);
        end
        if ($urandom_range(0, 4) != 0)
            send_word(32'h0, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin : result_monitor
        t_c40_beat want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual total_chars %0d",
                         $time, out_ch.total_chars);
                mismatch_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("char_a", 8'(want.char_a), 8'(out_ch.char_a));
                check_field("char_b", 8'(want.char_b), 8'(out_ch.char_b));
                check_field("char_c", 8'(want.char_c), 8'(out_ch.char_c));
                check_field("char_d", 8'(want.char_d), 8'(out_ch.char_d));
                check_field("char_e", 8'(want.char_e), 8'(out_ch.char_e));
                check_field("char_f", 8'(want.char_f), 8'(out_ch.char_f));
                check_field("chars_emitted", 8'(want.chars_emitted), 8'(out_ch.chars_emitted));
                check_field("list_ended", 8'(want.list_ended), 8'(out_ch.list_ended));
                check_field("decode_failed", 8'(want.decode_failed), 8'(out_ch.decode_failed));
                check_field("total_chars", 8'(want.total_chars), 8'(out_ch.total_chars));
            end
        end
    end

    // receiver: free, rotating stall mask, or a counted hold-off
    initial begin : sink_stall
        int unsigned hold_left;
        int unsigned hold_seen;
        logic [3:0]  phase;
        hold_left = 0;
        hold_seen = 0;
        phase     = '0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_mode == RX_PATTERN) begin
                out_ch.ready <= rx_mask[phase];
            end else begin
                out_ch.ready <= 1'b1;
            end
            phase++;
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic test_directed();
        rx_mode   = RX_FREE;
        tx_bursty = 1'b0;
        send_word({16'h0, pack_half(4, 4, 4)}, 1'b1);
        send_word({pack_half(13, 14, 39), pack_half(39, 39, 39)}, 1'b0);
        send_word(32'h0, 1'b0);
        send_word({16'h0, pack_half(20, 20, 20)}, 1'b0);   // ignored after end
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word({16'h0, pack_half(10, 10, 10)}, 1'b0);   // ignored after failure
        send_word({pack_half(5, 5, 5), 16'h0}, 1'b1);      // zero low under nonzero high
        send_word({16'h0, pack_half(3, 4, 4)}, 1'b1);
        send_word({16'h0, pack_half(4, 0, 4)}, 1'b1);
        send_word({16'h0, pack_half(4, 4, 0)}, 1'b1);
        send_word({16'h0, 16'd64001}, 1'b1);               // first digit 40
        send_word(32'h0, 1'b1);
        // exactly at the limit, then one word over
        for (int i = 0; i < 6; i++)
            send_word({pack_half(4 + i, 30, 39), pack_half(14 + i, 13, 4)}, i == 0);
        send_word({16'h0, pack_half(7, 8, 9)}, 1'b0);
        // 33 characters, then a six-character word
        for (int i = 0; i < 5; i++)
            send_word({pack_half(20 + i, 5, 6), pack_half(33, 12, 4 + i)}, i == 0);
        send_word({16'h0, pack_half(9, 9, 9)}, 1'b0);
        send_word({pack_half(4, 4, 4), pack_half(4, 4, 4)}, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_random_lists();
        int unsigned goal;
        goal = handled_words + 550;
        while (handled_words < goal) begin
            rx_mask   = 16'($urandom()) | 16'h1;
            rx_mode   = ($urandom_range(0, 3) == 0) ? RX_FREE : RX_PATTERN;
            tx_bursty = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4)) send_word($urandom(), 1'($urandom_range(0, 1)));
            else
                send_random_list();
        end
        wait_results_drained();
    endtask

    task automatic test_receiver_hold_off();
        int unsigned goal;
        goal      = handled_words + 40;
        rx_mode   = RX_FREE;
        tx_bursty = 1'b0;
        hold_len  = 400;
        hold_req++;
        while (handled_words < goal)
            send_random_list();
        wait_results_drained();
    endtask

    task automatic test_drain_pauses();
        repeat (12) begin
            rx_mask   = 16'($urandom()) | 16'h1;
            rx_mode   = RX_PATTERN;
            tx_bursty = 1'b1;
            send_random_list();
            wait_results_drained();
        end
    endtask

    task automatic test_back_to_back();
        int unsigned goal;
        goal      = handled_words + 200;
        rx_mode   = RX_FREE;
        tx_bursty = 1'b0;
        while (handled_words < goal)
            send_random_list();
        wait_results_drained();
    endtask

    initial begin
        list_total       = 0;
        list_done        = 1'b0;
        list_bad         = 1'b0;
        handled_words    = 0;
        mismatch_count   = 0;
        tx_bursty        = 1'b0;
        burst_left       = 0;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.id_word    <= '0;
        in_ch.list_start <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_lists();
        test_receiver_hold_off();
        test_drain_pauses();
        test_back_to_back();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
sv/c40idw_pkg.sv
sv/c40idw_if.sv
sv/c40idw_half_split.sv
sv/c40_id_word_decoder_unit.sv
sim/tb_c40_id_word_decoder_unit.sv
